// ===== src/csg_pkg.sv =====
package csg_pkg;

   localparam int COLUMNS = 80;
   localparam int ROWS    = 24;

   localparam int POS_W    = 11;
   localparam int BYTE_W   = 8;
   localparam int CNT_W    = 7;
   localparam int VAL_W    = 7;
   localparam int TMPL_LEN = 12;
   localparam int TMPL_W   = TMPL_LEN * BYTE_W;
   localparam int LOW_W    = 64;
   localparam int HIGH_W   = 32;
   localparam int CSR_IDX_W = 1;

   localparam int ROW_W  = (ROWS > 1) ? $clog2(ROWS) : 1;
   localparam int LIM_W  = 14;
   localparam logic [LIM_W-1:0] LIMIT = LIM_W'(ROWS * COLUMNS);

   localparam int REC_SHIFT = POS_W + $clog2(COLUMNS);
   localparam int PROD_W    = 2 * POS_W + 2;
   localparam logic [PROD_W-1:0] REC_MUL =
      PROD_W'(((1 << REC_SHIFT) + COLUMNS - 1) / COLUMNS);
   localparam logic [POS_W-1:0]  COL_DIV = POS_W'(COLUMNS);

   localparam int STEP_W = 2;
   localparam logic [STEP_W-1:0] STEP_ROW  = 2'd2;
   localparam logic [STEP_W-1:0] STEP_COL  = 2'd1;
   localparam logic [STEP_W-1:0] STEP_PUSH = 2'd0;

   localparam int QUEUE_DEPTH = 2;
   localparam int PTR_W       = 1;

   localparam logic [CSR_IDX_W-1:0] CSR_TEMPLATE_LOW  = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_TEMPLATE_HIGH = 1'b1;

   localparam logic [BYTE_W-1:0] BYTE_END   = 8'h00;
   localparam logic [BYTE_W-1:0] SEL_ROW    = 8'h80;
   localparam logic [BYTE_W-1:0] SEL_COL    = 8'h81;
   localparam logic [BYTE_W-1:0] OP_DEC     = 8'hFF;
   localparam logic [BYTE_W-1:0] ASCII_ZERO = 8'h30;
   localparam logic [BYTE_W-1:0] PAD_BYTE   = 8'h00;
   localparam logic [VAL_W-1:0]  DEC_BASE   = 7'd10;
   localparam logic [CNT_W-1:0]  CNT_ONE    = 7'd1;

   localparam int MUL_W     = VAL_W + BYTE_W;
   localparam int DIG_SHIFT = 11;
   localparam logic [MUL_W-1:0] DIV10_MUL = MUL_W'(205);

   typedef struct packed {
      logic [VAL_W-1:0] row;
      logic [VAL_W-1:0] col;
   } cell_type;

   function automatic logic [3:0] dec_tens(input logic [VAL_W-1:0] d);
      logic [MUL_W-1:0] p;
      p = MUL_W'(d) * DIV10_MUL;
      return 4'(p >> DIG_SHIFT);
   endfunction

   function automatic logic [3:0] dec_ones(input logic [VAL_W-1:0] d,
                                           input logic [3:0] tens);
      return 4'(d - VAL_W'(tens) * DEC_BASE);
   endfunction

endpackage

// ===== src/csg_req_if.sv =====
interface csg_req_if;
   logic                        valid;
   logic                        ready;
   logic [csg_pkg::POS_W-1:0]   position;

   modport source (output valid, output position, input ready);
   modport sink   (input valid, input position, output ready);
endinterface

// ===== src/csg_rsp_if.sv =====
interface csg_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [csg_pkg::BYTE_W-1:0]  out_byte;
   logic [csg_pkg::CNT_W-1:0]   repeat_count;
   logic                        last;

   modport source (output valid, output out_byte, output repeat_count, output last,
                   input ready);
   modport sink   (input valid, input out_byte, input repeat_count, input last,
                   output ready);
endinterface

// ===== src/csg_csr_if.sv =====
interface csg_csr_if;
   logic                          valid;
   logic                          ready;
   logic [csg_pkg::CSR_IDX_W-1:0] index;
   logic [csg_pkg::LOW_W-1:0]     data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== src/cursor_address_sequence_generator_core.sv =====
// Channel  Dir  Handshake      Payload
// req      in   valid/ready    position (11b, one-based cell index)
// rsp      out  valid/ready    out_byte (8b), repeat_count (7b), last (1b)
// csr      in   valid/ready    index (1b: template_low, template_high), data (64b)
//
// The front clamps a request on acceptance, forms the row by reciprocal multiply
// next cycle and the column by multiply-subtract the cycle after, then pushes it
// into a two-entry queue, stalling while full; req stays not ready until the push.
// The walker loads the template on a pop and gives one result per cycle unless
// rsp stalls, popping again only after the walk; an empty template emits nothing.
// Reset is synchronous and clears control state and the template.
module cursor_address_sequence_generator_core (
   input  logic        clock,
   input  logic        reset,
   csg_req_if.sink     req,
   csg_rsp_if.source   rsp,
   csg_csr_if.sink     csr
);

   logic [csg_pkg::LOW_W-1:0]   tmpl_low_ff, tmpl_low_in;
   logic [csg_pkg::HIGH_W-1:0]  tmpl_high_ff, tmpl_high_in;
   logic [csg_pkg::TMPL_W-1:0]  tmpl;

   logic                        push;
   csg_pkg::cell_type           push_data;
   logic                        q_full;
   logic                        pop;
   csg_pkg::cell_type           head;
   logic                        q_valid;

   assign csr.ready = 1'b1;
   assign tmpl      = {tmpl_high_ff, tmpl_low_ff};

   always_comb begin
      tmpl_low_in  = tmpl_low_ff;
      tmpl_high_in = tmpl_high_ff;
      if (csr.valid) begin
         case (csr.index)
            csg_pkg::CSR_TEMPLATE_LOW: begin
               tmpl_low_in = csr.data;
            end
            csg_pkg::CSR_TEMPLATE_HIGH: begin
               tmpl_high_in = csr.data[csg_pkg::HIGH_W-1:0];
            end
            default: begin
               tmpl_low_in = tmpl_low_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tmpl_low_ff  <= '0;
         tmpl_high_ff <= '0;
      end else begin
         tmpl_low_ff  <= tmpl_low_in;
         tmpl_high_ff <= tmpl_high_in;
      end
   end

   csg_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req       (req),
      .push      (push),
      .push_data (push_data),
      .q_full    (q_full)
   );

   csg_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .full      (q_full),
      .pop       (pop),
      .head      (head),
      .q_valid   (q_valid)
   );

   csg_back u_back (
      .clock   (clock),
      .reset   (reset),
      .head    (head),
      .q_valid (q_valid),
      .pop     (pop),
      .tmpl    (tmpl),
      .rsp     (rsp)
   );

endmodule

// ===== src/csg_front.sv =====
module csg_front (
   input  logic                clock,
   input  logic                reset,
   csg_req_if.sink             req,
   output logic                push,
   output csg_pkg::cell_type   push_data,
   input  logic                q_full
);

   logic                            busy_ff, busy_in;
   logic [csg_pkg::STEP_W-1:0]      step_ff, step_in;
   logic [csg_pkg::POS_W-1:0]       rem_ff, rem_in;
   logic [csg_pkg::ROW_W-1:0]       quo_ff, quo_in;
   logic [csg_pkg::LIM_W-1:0]       pos_ext;
   logic [csg_pkg::LIM_W-1:0]       pos_clamp;
   logic [csg_pkg::POS_W-1:0]       base;
   logic [csg_pkg::PROD_W-1:0]      prod;
   logic [csg_pkg::POS_W-1:0]       row_base;

   assign req.ready = !busy_ff;

   always_comb begin
      pos_ext = csg_pkg::LIM_W'(req.position);
      pos_clamp = pos_ext;
      if (pos_ext == '0) begin
         pos_clamp = csg_pkg::LIM_W'(1);
      end else if (pos_ext > csg_pkg::LIMIT) begin
         pos_clamp = csg_pkg::LIMIT;
      end
      base = csg_pkg::POS_W'(pos_clamp - csg_pkg::LIM_W'(1));
   end

   assign prod     = csg_pkg::PROD_W'(rem_ff) * csg_pkg::REC_MUL;
   assign row_base = csg_pkg::POS_W'(quo_ff) * csg_pkg::COL_DIV;

   always_comb begin
      busy_in = busy_ff;
      step_in = step_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      if (req.valid && !busy_ff) begin
         busy_in = 1'b1;
         step_in = csg_pkg::STEP_ROW;
         rem_in  = base;
      end else if (busy_ff && step_ff == csg_pkg::STEP_ROW) begin
         quo_in  = csg_pkg::ROW_W'(prod >> csg_pkg::REC_SHIFT);
         step_in = csg_pkg::STEP_COL;
      end else if (busy_ff && step_ff == csg_pkg::STEP_COL) begin
         rem_in  = rem_ff - row_base;
         step_in = csg_pkg::STEP_PUSH;
      end else if (busy_ff && !q_full) begin
         busy_in = 1'b0;
      end
   end

   assign push          = busy_ff && (step_ff == csg_pkg::STEP_PUSH) && !q_full;
   assign push_data.row = csg_pkg::VAL_W'(quo_ff);
   assign push_data.col = csg_pkg::VAL_W'(rem_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         step_ff <= csg_pkg::STEP_PUSH;
      end else begin
         busy_ff <= busy_in;
         step_ff <= step_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

endmodule

// ===== src/csg_queue.sv =====
module csg_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  csg_pkg::cell_type   push_data,
   output logic                full,
   input  logic                pop,
   output csg_pkg::cell_type   head,
   output logic                q_valid
);

   csg_pkg::cell_type               mem [csg_pkg::QUEUE_DEPTH];
   logic [csg_pkg::PTR_W-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [csg_pkg::PTR_W-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [csg_pkg::PTR_W:0]         cnt_ff, cnt_in;

   function automatic logic [csg_pkg::PTR_W-1:0] ptr_next(
      input logic [csg_pkg::PTR_W-1:0] p);
      if (p == csg_pkg::PTR_W'(csg_pkg::QUEUE_DEPTH - 1)) begin
         return '0;
      end
      return p + csg_pkg::PTR_W'(1);
   endfunction

   assign full    = cnt_ff == (csg_pkg::PTR_W + 1)'(csg_pkg::QUEUE_DEPTH);
   assign q_valid = cnt_ff != '0;
   assign head    = mem[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ptr_next(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop  ? ptr_next(rd_ptr_ff) : rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push && !pop) begin
         cnt_in = cnt_ff + (csg_pkg::PTR_W + 1)'(1);
      end else if (pop && !push) begin
         cnt_in = cnt_ff - (csg_pkg::PTR_W + 1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
      if (push) begin
         mem[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== src/csg_back.sv =====
module csg_back (
   input  logic                        clock,
   input  logic                        reset,
   input  csg_pkg::cell_type           head,
   input  logic                        q_valid,
   output logic                        pop,
   input  logic [csg_pkg::TMPL_W-1:0]  tmpl,
   csg_rsp_if.source                   rsp
);

   logic                            busy_ff, busy_in;
   logic                            pend_ff, pend_in;
   logic [csg_pkg::TMPL_W-1:0]      walk_ff, walk_in;
   logic [csg_pkg::VAL_W-1:0]       row_ff, row_in;
   logic [csg_pkg::VAL_W-1:0]       col_ff, col_in;
   logic                            ov_ff, ov_in;
   logic [csg_pkg::BYTE_W-1:0]      ob_ff, ob_in;
   logic [csg_pkg::CNT_W-1:0]       oc_ff, oc_in;
   logic                            ol_ff, ol_in;

   logic [csg_pkg::BYTE_W-1:0]      b0, b1, b2;
   logic [csg_pkg::VAL_W-1:0]       v, d;
   logic [3:0]                      tens, ones;
   logic                            take;
   logic                            emit;
   logic [csg_pkg::BYTE_W-1:0]      eb;
   logic [csg_pkg::CNT_W-1:0]       ec;
   logic                            el;

   assign b0   = walk_ff[csg_pkg::BYTE_W-1:0];
   assign b1   = walk_ff[2*csg_pkg::BYTE_W-1:csg_pkg::BYTE_W];
   assign b2   = walk_ff[3*csg_pkg::BYTE_W-1:2*csg_pkg::BYTE_W];
   assign v    = (b0 == csg_pkg::SEL_COL) ? col_ff : row_ff;
   assign d    = v + csg_pkg::VAL_W'(1);
   assign tens = csg_pkg::dec_tens(d);
   assign ones = csg_pkg::dec_ones(d, tens);
   assign take = !ov_ff || rsp.ready;
   assign pop  = !busy_ff && q_valid;

   always_comb begin
      busy_in = busy_ff;
      pend_in = pend_ff;
      walk_in = walk_ff;
      row_in  = row_ff;
      col_in  = col_ff;
      ov_in   = ov_ff && !rsp.ready;
      ob_in   = ob_ff;
      oc_in   = oc_ff;
      ol_in   = ol_ff;
      emit    = 1'b0;
      eb      = csg_pkg::PAD_BYTE;
      ec      = csg_pkg::CNT_ONE;
      el      = 1'b0;
      if (pop) begin
         busy_in = 1'b1;
         pend_in = 1'b0;
         walk_in = tmpl;
         row_in  = head.row;
         col_in  = head.col;
      end else if (busy_ff && take) begin
         if (pend_ff) begin
            emit    = 1'b1;
            eb      = csg_pkg::ASCII_ZERO + csg_pkg::BYTE_W'(ones);
            el      = b2 == csg_pkg::BYTE_END;
            walk_in = walk_ff >> (2 * csg_pkg::BYTE_W);
            pend_in = 1'b0;
         end else if (b0 == csg_pkg::BYTE_END) begin
            busy_in = 1'b0;
         end else if (b0 < csg_pkg::SEL_ROW) begin
            emit    = 1'b1;
            eb      = b0;
            el      = b1 == csg_pkg::BYTE_END;
            walk_in = walk_ff >> csg_pkg::BYTE_W;
         end else if (b0 == csg_pkg::SEL_ROW || b0 == csg_pkg::SEL_COL) begin
            emit = 1'b1;
            if (b1 == csg_pkg::OP_DEC && d >= csg_pkg::DEC_BASE) begin
               eb      = csg_pkg::ASCII_ZERO + csg_pkg::BYTE_W'(tens);
               pend_in = 1'b1;
            end else if (b1 == csg_pkg::OP_DEC) begin
               eb      = csg_pkg::ASCII_ZERO + csg_pkg::BYTE_W'(ones);
               el      = b2 == csg_pkg::BYTE_END;
               walk_in = walk_ff >> (2 * csg_pkg::BYTE_W);
            end else begin
               eb      = csg_pkg::BYTE_W'(v) + b1;
               el      = b2 == csg_pkg::BYTE_END;
               walk_in = walk_ff >> (2 * csg_pkg::BYTE_W);
            end
         end else begin
            emit    = 1'b1;
            eb      = csg_pkg::PAD_BYTE;
            ec      = b0[csg_pkg::CNT_W-1:0];
            el      = b1 == csg_pkg::BYTE_END;
            walk_in = walk_ff >> csg_pkg::BYTE_W;
         end
         if (emit) begin
            ov_in = 1'b1;
            ob_in = eb;
            oc_in = ec;
            ol_in = el;
            if (el) begin
               busy_in = 1'b0;
            end
         end
      end
   end

   assign rsp.valid        = ov_ff;
   assign rsp.out_byte     = ob_ff;
   assign rsp.repeat_count = oc_ff;
   assign rsp.last         = ol_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         pend_ff <= 1'b0;
         ov_ff   <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         pend_ff <= pend_in;
         ov_ff   <= ov_in;
      end
      walk_ff <= walk_in;
      row_ff  <= row_in;
      col_ff  <= col_in;
      ob_ff   <= ob_in;
      oc_ff   <= oc_in;
      ol_ff   <= ol_in;
   end

endmodule

// ===== bench/cursor_address_sequence_generator_core_test.sv =====
module cursor_address_sequence_generator_core_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int MAX_BYTES      = 12;
   localparam int SETTLE_CYCLES  = 48;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int HOLD_OFF       = 300;
   localparam logic [csg_pkg::BYTE_W-1:0] PAD_MASK = 8'h7F;

   typedef struct packed {
      logic [csg_pkg::BYTE_W-1:0] out_byte;
      logic [csg_pkg::CNT_W-1:0]  repeat_count;
      logic                       last;
   } cursor_byte_type;

   logic clock = 1'b0;
   logic reset;

   csg_req_if req_bus ();
   csg_rsp_if rsp_bus ();
   csg_csr_if csr_bus ();

   cursor_address_sequence_generator_core dut (
      .clock (clock),
      .reset (reset),
      .req   (req_bus),
      .rsp   (rsp_bus),
      .csr   (csr_bus)
   );

   logic [csg_pkg::LOW_W-1:0]  tmpl_low;
   logic [csg_pkg::HIGH_W-1:0] tmpl_high;
   cursor_byte_type   walk_bytes[$];
   cursor_byte_type   expected_bytes[$];
   int                rsp_hold_cycles;
   int                mismatch_count;
   int                positions_sent;
   int                bytes_checked;
   int                templates_loaded;
   int                idle_cycles;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic logic [csg_pkg::BYTE_W-1:0] template_slot(input int slot);
      if (slot < 8)
         return tmpl_low[slot*csg_pkg::BYTE_W +: csg_pkg::BYTE_W];
      return tmpl_high[(slot-8)*csg_pkg::BYTE_W +: csg_pkg::BYTE_W];
   endfunction

   function automatic void append_cursor_byte(input logic [csg_pkg::BYTE_W-1:0] b,
                                              input logic [csg_pkg::CNT_W-1:0] count);
      cursor_byte_type entry;
      entry.out_byte     = b;
      entry.repeat_count = count;
      entry.last         = 1'b0;
      if (walk_bytes.size() < MAX_BYTES)
         walk_bytes.push_back(entry);
   endfunction

   function automatic void expand_cursor_sequence(
      input logic [csg_pkg::POS_W-1:0] position);
      int unsigned                cell_idx;
      int unsigned                row;
      int unsigned                col;
      int unsigned                value;
      int unsigned                d;
      int                         slot;
      logic [csg_pkg::BYTE_W-1:0] code;
      logic [csg_pkg::BYTE_W-1:0] op;
      cell_idx = position;
      if (cell_idx < 1)
         cell_idx = 1;
      if (cell_idx > csg_pkg::ROWS * csg_pkg::COLUMNS)
         cell_idx = csg_pkg::ROWS * csg_pkg::COLUMNS;
      cell_idx = cell_idx - 1;
      row  = cell_idx / csg_pkg::COLUMNS;
      col  = cell_idx % csg_pkg::COLUMNS;
      walk_bytes.delete();
      slot = 0;
      while (slot < csg_pkg::TMPL_LEN) begin
         code = template_slot(slot);
         if (code == csg_pkg::BYTE_END)
            break;
         if (code < csg_pkg::SEL_ROW) begin
            append_cursor_byte(code, csg_pkg::CNT_ONE);
         end else if (code == csg_pkg::SEL_ROW || code == csg_pkg::SEL_COL) begin
            value = (code == csg_pkg::SEL_ROW) ? row : col;
            slot++;
            if (slot >= csg_pkg::TMPL_LEN) begin
               append_cursor_byte(csg_pkg::BYTE_W'(value), csg_pkg::CNT_ONE);
               break;
            end
            op = template_slot(slot);
            if (op == csg_pkg::OP_DEC) begin
               d = value + 1;
               if (d >= 100)
                  append_cursor_byte(csg_pkg::ASCII_ZERO
                                     + csg_pkg::BYTE_W'((d / 100) % 10),
                                     csg_pkg::CNT_ONE);
               if (d >= 10)
                  append_cursor_byte(csg_pkg::ASCII_ZERO
                                     + csg_pkg::BYTE_W'((d / 10) % 10),
                                     csg_pkg::CNT_ONE);
               append_cursor_byte(csg_pkg::ASCII_ZERO + csg_pkg::BYTE_W'(d % 10),
                                  csg_pkg::CNT_ONE);
            end else begin
               append_cursor_byte(csg_pkg::BYTE_W'(value + op), csg_pkg::CNT_ONE);
            end
         end else begin
            append_cursor_byte(csg_pkg::PAD_BYTE, csg_pkg::CNT_W'(code & PAD_MASK));
         end
         slot++;
      end
      if (walk_bytes.size() > 0)
         walk_bytes[walk_bytes.size()-1].last = 1'b1;
      foreach (walk_bytes[i])
         expected_bytes.push_back(walk_bytes[i]);
   endfunction

   always @(posedge clock) begin : rsp_check
      cursor_byte_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         bytes_checked++;
         if (expected_bytes.size() == 0) begin
            $error("unexpected result out_byte %0h repeat_count %0d last %0b",
                   rsp_bus.out_byte, rsp_bus.repeat_count, rsp_bus.last);
            mismatch_count++;
         end else begin
            want = expected_bytes.pop_front();
            if (rsp_bus.out_byte !== want.out_byte) begin
               $error("out_byte expected %0h actual %0h", want.out_byte, rsp_bus.out_byte);
               mismatch_count++;
            end
            if (rsp_bus.repeat_count !== want.repeat_count) begin
               $error("repeat_count expected %0d actual %0d",
                      want.repeat_count, rsp_bus.repeat_count);
               mismatch_count++;
            end
            if (rsp_bus.last !== want.last) begin
               $error("last expected %0b actual %0b", want.last, rsp_bus.last);
               mismatch_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)
          || (csr_bus.valid && csr_bus.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin : rsp_stall_pattern
      int run;
      int mode;
      run = 0;
      mode = 0;
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (rsp_hold_cycles != 0) begin
            rsp_bus.ready = 1'b0;
            repeat (rsp_hold_cycles) @(negedge clock);
            rsp_hold_cycles = 0;
         end
         if (run == 0) begin
            run  = $urandom_range(8, 64);
            mode = $urandom_range(0, 3);
         end
         run--;
         case (mode)
            0:       rsp_bus.ready = 1'b1;
            1:       rsp_bus.ready = $urandom_range(0, 1);
            2:       rsp_bus.ready = ($urandom_range(0, 3) == 0);
            default: rsp_bus.ready = ($urandom_range(0, 7) != 0);
         endcase
      end
   end

   task automatic write_template(input logic [csg_pkg::LOW_W-1:0] low_data,
                                 input logic [csg_pkg::LOW_W-1:0] high_data);
      csr_bus.valid = 1'b1;
      csr_bus.index = csg_pkg::CSR_TEMPLATE_LOW;
      csr_bus.data  = low_data;
      do @(posedge clock); while (!csr_bus.ready);
      tmpl_low = low_data;
      @(negedge clock);
      csr_bus.index = csg_pkg::CSR_TEMPLATE_HIGH;
      csr_bus.data  = high_data;
      do @(posedge clock); while (!csr_bus.ready);
      tmpl_high = high_data[csg_pkg::HIGH_W-1:0];
      @(negedge clock);
      csr_bus.valid = 1'b0;
      templates_loaded++;
   endtask

   task automatic send_position(input logic [csg_pkg::POS_W-1:0] position);
      req_bus.valid    = 1'b1;
      req_bus.position = position;
      do @(posedge clock); while (!req_bus.ready);
      expand_cursor_sequence(position);
      positions_sent++;
      @(negedge clock);
   endtask

   task automatic pause_sender(input int cycles);
      if (cycles > 0) begin
         req_bus.valid = 1'b0;
         repeat (cycles) @(negedge clock);
      end
   endtask

   task automatic wait_for_idle();
      req_bus.valid = 1'b0;
      while (expected_bytes.size() != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   function automatic logic [csg_pkg::POS_W-1:0] random_position();
      int pick;
      pick = $urandom_range(0, 9);
      if (pick < 7)
         return csg_pkg::POS_W'($urandom_range(1, csg_pkg::ROWS * csg_pkg::COLUMNS));
      if (pick < 9)
         return csg_pkg::POS_W'($urandom_range(0, csg_pkg::ROWS - 1) * csg_pkg::COLUMNS
                                + ($urandom_range(0, 1) ? csg_pkg::COLUMNS : 1));
      if ($urandom_range(0, 1))
         return '0;
      return csg_pkg::POS_W'($urandom_range(csg_pkg::ROWS * csg_pkg::COLUMNS + 1,
                                            (1 << csg_pkg::POS_W) - 1));
   endfunction

   function automatic logic [csg_pkg::TMPL_W-1:0] random_template();
      logic [csg_pkg::TMPL_W-1:0] t;
      int                         slot;
      int                         pick;
      t = '0;
      slot = 0;
      while (slot < csg_pkg::TMPL_LEN) begin
         pick = $urandom_range(0, 99);
         if (pick < 40) begin
            t[slot*csg_pkg::BYTE_W +: csg_pkg::BYTE_W] =
               csg_pkg::BYTE_W'($urandom_range(1, 127));
         end else if (pick < 72) begin
            t[slot*csg_pkg::BYTE_W +: csg_pkg::BYTE_W] =
               $urandom_range(0, 1) ? csg_pkg::SEL_COL : csg_pkg::SEL_ROW;
            slot++;
            if (slot < csg_pkg::TMPL_LEN)
               t[slot*csg_pkg::BYTE_W +: csg_pkg::BYTE_W] =
                  $urandom_range(0, 1) ? csg_pkg::OP_DEC
                                       : csg_pkg::BYTE_W'($urandom_range(0, 255));
         end else if (pick < 90) begin
            t[slot*csg_pkg::BYTE_W +: csg_pkg::BYTE_W] =
               csg_pkg::BYTE_W'($urandom_range(8'h82, 8'hFF));
         end else begin
            t[slot*csg_pkg::BYTE_W +: csg_pkg::BYTE_W] = csg_pkg::BYTE_END;
         end
         slot++;
      end
      return t;
   endfunction

   task automatic test_empty_template();
      send_position(1);
      send_position(csg_pkg::ROWS * csg_pkg::COLUMNS);
      wait_for_idle();
   endtask

   task automatic test_decimal_template();
      write_template(64'h48FF_813B_FF80_5B1B, 64'h0);
      send_position(1);
      send_position(csg_pkg::ROWS * csg_pkg::COLUMNS);
      send_position(0);
      send_position(11'h7FF);
      pause_sender(3);
      send_position(csg_pkg::COLUMNS);
      send_position(csg_pkg::COLUMNS + 1);
      send_position(1024);
      wait_for_idle();
   endtask

   task automatic test_offset_template();
      write_template(64'hFF82_0081_2080_591B, 64'hA5C3_0F96_807F_01A5);
      send_position(1);
      send_position(csg_pkg::ROWS * csg_pkg::COLUMNS);
      send_position(1700);
      wait_for_idle();
      write_template(64'hFF81_FF80_F081_FE80, 64'h0000_0000_FF81_FF80);
      send_position(1);
      send_position(csg_pkg::ROWS * csg_pkg::COLUMNS);
      send_position(960);
      wait_for_idle();
   endtask

   task automatic test_full_template();
      write_template(64'h3930_2041_552A_7F01, 64'h0000_0000_810D_0A7E);
      send_position(1024);
      send_position(1);
      wait_for_idle();
      write_template(64'h7F7F_7F7F_7F7F_7F00, 64'h0000_0000_7F7F_7F7F);
      send_position(500);
      wait_for_idle();
      write_template('1, '1);
      send_position(1919);
      wait_for_idle();
   endtask

   task automatic test_backpressure();
      write_template(64'h3930_2041_552A_7F01, 64'h0000_0000_810D_0A7E);
      rsp_hold_cycles = HOLD_OFF;
      repeat (24) send_position(random_position());
      wait_for_idle();
   endtask

   task automatic test_random_templates(input int phases, input int per_phase);
      logic [csg_pkg::TMPL_W-1:0] t;
      int                         sent;
      int                         burst;
      for (int p = 0; p < phases; p++) begin
         t = random_template();
         write_template(t[csg_pkg::LOW_W-1:0],
                        {32'($urandom), t[csg_pkg::TMPL_W-1:csg_pkg::LOW_W]});
         sent = 0;
         while (sent < per_phase) begin
            burst = $urandom_range(1, 8);
            for (int i = 0; i < burst && sent < per_phase; i++) begin
               send_position(random_position());
               sent++;
            end
            pause_sender(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12));
         end
         wait_for_idle();
      end
   endtask

   initial begin
      reset            = 1'b1;
      req_bus.valid    = 1'b0;
      req_bus.position = '0;
      csr_bus.valid    = 1'b0;
      csr_bus.index    = csg_pkg::CSR_TEMPLATE_LOW;
      csr_bus.data     = '0;
      tmpl_low         = '0;
      tmpl_high        = '0;
      rsp_hold_cycles  = 0;
      mismatch_count   = 0;
      positions_sent   = 0;
      bytes_checked    = 0;
      templates_loaded = 0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_empty_template();
      test_decimal_template();
      test_offset_template();
      test_full_template();
      test_backpressure();
      test_random_templates(7, 24);

      $display("covered %0d positions over %0d templates, %0d cursor bytes checked",
               positions_sent, templates_loaded, bytes_checked);
      $display("included clamped positions, selectors in the last slot, decimal and padding");
      if (mismatch_count == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

// ===== cursor_address_sequence_generator_core.f =====
src/csg_pkg.sv
src/csg_req_if.sv
src/csg_rsp_if.sv
src/csg_csr_if.sv
src/csg_front.sv
src/csg_queue.sv
src/csg_back.sv
src/cursor_address_sequence_generator_core.sv
bench/cursor_address_sequence_generator_core_test.sv
